// File: rtl/heq_pkg.sv
// Shared constants, types and helpers of the histogram equalizer.
`default_nettype none
package heq_pkg;

  localparam int BINS      = 256;
  localparam int IDX_W     = $clog2(BINS);
  localparam int COUNT_W   = 25;
  localparam int LEVEL_W   = 8;
  localparam int READ_W    = 8;
  localparam int STEP_W    = $clog2(LEVEL_W);
  localparam int SCALED_W  = COUNT_W + LEVEL_W;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SUM   = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Add with saturation at the all-ones count.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/histogram_equalizer.sv
// Top level of the 256-bin histogram equalizer.
`default_nettype none
// Histogram equalizer. Source histogram bins arrive in order on the input
// channel with mode = 0; first_bin = 1 marks bin zero of a new histogram and
// restarts the cumulative sum, the written-bin mask and the peak. Each bin's
// level is floor(255 * cumulative / pixel_count), saturated at 255, and the
// bin count is added into the equalized histogram entry at that level. The
// result carries the level, the updated entry and the pass peak. mode = 1
// reads one equalized entry (unwritten entries read as zero). pixel_count is
// written through cfg_write/cfg_data; the user must do so only while the
// block is idle, since the block does not enforce it. Zero flags an error and
// accumulate requests are then ignored. Timing: one request at a time. An
// accumulate request passes through sum, scale, 8 restoring divide steps of
// one quotient bit each, the synchronous store read and the update before its
// result is valid; when the level saturates at 255 the divide is skipped. A
// read request and an accumulate with a zero pixel count go straight to the
// update, the store read overlapping the accept. The block returns to idle
// between requests and takes no new request before the last one is through.
// The input is free again as soon as the result is registered, so a waiting
// result does not block the next request. The store needs no clearing pass after reset.
module histogram_equalizer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [heq_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic                          first_bin,
  input  wire logic [heq_pkg::COUNT_W-1:0]   bin_count,
  input  wire logic [heq_pkg::READ_W-1:0]    read_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [heq_pkg::LEVEL_W-1:0]        mapped_level,
  output logic [heq_pkg::COUNT_W-1:0]        equalized_value,
  output logic [heq_pkg::COUNT_W-1:0]        peak_value,
  output logic                               error_flag
);
  import heq_pkg::*;

  // Control and state registers
  state_t               state, state_next;
  logic [COUNT_W-1:0]   pixel_count;
  logic [COUNT_W-1:0]   running_sum;
  logic [COUNT_W-1:0]   peak_count;
  logic [BINS-1:0]      mask;
  logic [STEP_W-1:0]    step;

  // Captured request
  logic                 req_mode;
  logic                 req_first;
  logic                 req_err;
  logic [COUNT_W-1:0]   req_count;

  // Divider datapath
  logic [COUNT_W-1:0]   rem;
  logic [LEVEL_W-1:0]   num_lo;
  logic [LEVEL_W-1:0]   quot;

  // Store access
  logic [IDX_W-1:0]     slot;
  logic                 slot_ok;
  logic [COUNT_W-1:0]   store [BINS];
  logic [COUNT_W-1:0]   rdata;
  logic [IDX_W-1:0]     raddr;
  logic                 ren;
  logic                 wen;

  // Combinational helpers
  logic                 accept;
  logic                 out_free;
  logic [COUNT_W-1:0]   sum_next;
  logic [SCALED_W-1:0]  scaled;
  logic [COUNT_W-1:0]   scaled_hi;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     trial_sub;
  logic                 take;
  logic [IDX_W-1:0]     level_slot;
  logic [COUNT_W-1:0]   old_value;
  logic [COUNT_W-1:0]   acc_value;
  logic [COUNT_W-1:0]   peak_next;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Cumulative count; a first bin restarts it.
  assign sum_next = sat_add(req_first ? '0 : running_sum, req_count);

  // 255 * sum as sum * 256 - sum. The upper part is the first partial
  // remainder; if it already reaches the divisor the level saturates.
  assign scaled    = {running_sum, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, running_sum};
  assign scaled_hi = scaled[SCALED_W-1:LEVEL_W];

  // One restoring divide step: shift in the next numerator bit, try subtract.
  assign trial     = {rem, num_lo[LEVEL_W-1]};
  assign trial_sub = trial - {1'b0, pixel_count};
  assign take      = (trial >= {1'b0, pixel_count});

  // Level to store slot, clipped to the last bin.
  assign level_slot = (int'(quot) >= BINS) ? IDX_W'(BINS - 1) : IDX_W'(quot);

  // Store read: request index in idle, level slot after the divide.
  assign ren   = (accept && mode) || (state == ST_READ);
  assign raddr = (state == ST_IDLE) ? IDX_W'(read_index) : level_slot;

  // Read-modify-write of the entry; invalid entries count as zero.
  assign old_value = (slot_ok && mask[slot]) ? rdata : '0;
  assign acc_value = sat_add(old_value, req_count);
  assign peak_next = (acc_value > peak_count) ? acc_value : peak_count;
  assign wen       = (state == ST_DONE) && out_free && !req_mode && !req_err;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode || (pixel_count == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM:   state_next = ST_SCALE;
      ST_SCALE: state_next = (scaled_hi >= pixel_count) ? ST_READ : ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(LEVEL_W - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pixel_count <= '0;
      running_sum <= '0;
      peak_count  <= '0;
      mask        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        pixel_count <= cfg_data;
      end
      if (state == ST_SUM) begin
        running_sum <= sum_next;
        if (req_first) begin
          mask       <= '0;
          peak_count <= '0;
        end
      end
      if (wen) begin
        mask[slot] <= 1'b1;
        peak_count <= peak_next;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, divider and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_first <= first_bin;
      req_count <= bin_count;
      req_err   <= (pixel_count == '0);
      slot      <= IDX_W'(read_index);
      slot_ok   <= (int'(read_index) < BINS);
    end
    case (state)
      ST_SCALE: begin
        rem    <= scaled_hi;
        num_lo <= scaled[LEVEL_W-1:0];
        step   <= '0;
        quot   <= {LEVEL_W{1'b1}};
      end
      ST_DIV: begin
        rem    <= take ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
        num_lo <= num_lo << 1;
        quot   <= {quot[LEVEL_W-2:0], take};
        step   <= step + 1'b1;
      end
      ST_READ: begin
        slot    <= level_slot;
        slot_ok <= 1'b1;
      end
      default: ;
    endcase
    if ((state == ST_DONE) && out_free) begin
      if (req_mode) begin
        mapped_level    <= '0;
        equalized_value <= old_value;
        peak_value      <= peak_count;
        error_flag      <= req_err;
      end else if (req_err) begin
        mapped_level    <= '0;
        equalized_value <= '0;
        peak_value      <= peak_count;
        error_flag      <= 1'b1;
      end else begin
        mapped_level    <= quot;
        equalized_value <= acc_value;
        peak_value      <= peak_next;
        error_flag      <= 1'b0;
      end
    end
  end

  // Equalized histogram store with a registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      store[slot] <= acc_value;
    end
    if (ren) begin
      rdata <= store[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/heq_checker.sv
// Port-level checks of the histogram equalizer and their bind.
`default_nettype none
module heq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [heq_pkg::LEVEL_W-1:0]   mapped_level,
  input wire logic [heq_pkg::COUNT_W-1:0]   equalized_value,
  input wire logic [heq_pkg::COUNT_W-1:0]   peak_value,
  input wire logic                          error_flag
);
  import heq_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mapped_level) &&
      $stable(equalized_value) && $stable(peak_value) && $stable(error_flag))
    else $error("stalled result changed");

  // One request at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // Error results carry no level; read results carry none either, but only error results are checked here.
  a_err_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> mapped_level == '0)
    else $error("level set on error result");

  // Every entry written in this pass is bounded by the pass peak.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> equalized_value <= peak_value)
    else $error("entry above peak");

endmodule

bind histogram_equalizer heq_checker u_heq_checker (.*);
`default_nettype wire

// File: dv/histogram_equalizer_tb.sv
// Self-checking testbench for the histogram equalizer: directed and random histogram passes.
`default_nettype none
module histogram_equalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import heq_pkg::*;

  // Request modes on the input channel.
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam int unsigned LEVEL_MAX     = 255;
  localparam int unsigned BIN_COUNT_MAX = 16777216;   // largest legal count and pixel count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Random stimulus size; the tail of the run goes without any idling.
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_FROM   = RANDOM_ITEMS - 150;

  // One result as the block should present it.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] value;
    logic [COUNT_W-1:0] peak;
    logic               err;
  } bin_result_t;

  // Shadow of the equalizer state plus the queue of results still owed.
  class equalization_scoreboard;
    logic [COUNT_W-1:0] pixel_count;
    logic [COUNT_W-1:0] running_sum;
    logic [COUNT_W-1:0] peak_count;
    logic [COUNT_W-1:0] eq_count[BINS];
    bit                 live_bin[BINS];
    bit                 ever_written[BINS];
    int                 written_slots[$];
    bin_result_t        expected_bins[$];
    int                 failures;

    function new();
      pixel_count = '0;
      running_sum = '0;
      peak_count  = '0;
      failures    = 0;
      foreach (live_bin[i]) begin
        live_bin[i]     = 1'b0;
        ever_written[i] = 1'b0;
        eq_count[i]     = '0;
      end
    endfunction

    function logic [COUNT_W-1:0] saturating_sum(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
      longint unsigned total;
      total = longint'(a) + longint'(b);
      if (total > longint'(COUNT_MAX)) return COUNT_MAX;
      return total[COUNT_W-1:0];
    endfunction

    function int pick_written_bin();
      return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    // Update the shadow state for an accepted request and queue its result.
    function void take_request(logic m, logic first, logic [COUNT_W-1:0] count,
                               logic [READ_W-1:0] idx);
      bin_result_t exp;
      logic [SCALED_W-1:0] scaled;
      logic [SCALED_W-1:0] quot;
      int slot;
      exp = '0;
      exp.err = (pixel_count == 0);
      if (m == MODE_READ) begin
        if (live_bin[idx]) exp.value = eq_count[idx];
        exp.peak = peak_count;
      end else if (exp.err) begin
        // empty image: request dropped, state untouched
        exp.peak = peak_count;
      end else begin
        if (first) begin
          running_sum = '0;
          peak_count  = '0;
          foreach (live_bin[i]) live_bin[i] = 1'b0;
        end
        running_sum = saturating_sum(running_sum, count);
        scaled = SCALED_W'(running_sum) * LEVEL_MAX;
        quot = scaled / SCALED_W'(pixel_count);
        exp.level = (quot > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : quot[LEVEL_W-1:0];
        slot = exp.level;
        exp.value = saturating_sum(live_bin[slot] ? eq_count[slot] : '0, count);
        eq_count[slot] = exp.value;
        live_bin[slot] = 1'b1;
        if (!ever_written[slot]) begin
          ever_written[slot] = 1'b1;
          written_slots = {written_slots, slot};
        end
        if (exp.value > peak_count) peak_count = exp.value;
        exp.peak = peak_count;
      end
      expected_bins = {expected_bins, exp};
    endfunction

    function void check_bin_result(logic [LEVEL_W-1:0] level, logic [COUNT_W-1:0] value,
                                   logic [COUNT_W-1:0] peak, logic err);
      bin_result_t exp;
      if (expected_bins.size() == 0) begin
        $error("unexpected result: mapped_level %0d equalized_value %0d", level, value);
        failures++;
        return;
      end
      exp = expected_bins.pop_front();
      if (level !== exp.level) begin
        $error("mapped_level: expected %0d, got %0d", exp.level, level);
        failures++;
      end
      if (value !== exp.value) begin
        $error("equalized_value: expected %0d, got %0d", exp.value, value);
        failures++;
      end
      if (peak !== exp.peak) begin
        $error("peak_value: expected %0d, got %0d", exp.peak, peak);
        failures++;
      end
      if (err !== exp.err) begin
        $error("error_flag: expected %0d, got %0d", exp.err, err);
        failures++;
      end
    endfunction
  endclass

  // DUT-facing signals; every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = MODE_ACCUM;
  logic               first_bin = 1'b0;
  logic [COUNT_W-1:0] bin_count = '0;
  logic [READ_W-1:0]  read_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LEVEL_W-1:0] mapped_level;
  logic [COUNT_W-1:0] equalized_value;
  logic [COUNT_W-1:0] peak_value;
  logic               error_flag;

  equalization_scoreboard sb;
  bit quiet = 1'b0;    // no idling on either side once set
  int taken = 0;       // random requests counted toward the stimulus size
  int stall_left = 0;

  histogram_equalizer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .first_bin(first_bin),
    .bin_count(bin_count),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mapped_level(mapped_level),
    .equalized_value(equalized_value),
    .peak_value(peak_value),
    .error_flag(error_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: random stall bursts of random length, none in the tail.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 10);
    end
  end

  // Result monitor: values seen at the edge are the ones the handshake moved.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_bin_result(mapped_level, equalized_value, peak_value, error_flag);
  end

  // Present one request, optionally after a sender gap, and hold it until accepted.
  // valid stays high on return so back-to-back requests need no second assignment.
  task automatic send_request(input logic m, input logic first, input logic [COUNT_W-1:0] count,
                              input logic [READ_W-1:0] idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    first_bin  <= first;
    bin_count  <= count;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_request(m, first, count, idx);
  endtask

  // Read request on a bin the store has held at least once; first_bin and count are noise.
  task automatic send_read(input int idx);
    send_request(MODE_READ, 1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, BIN_COUNT_MAX)),
                 READ_W'(idx));
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
  endtask

  // pixel_count only changes with the block idle.
  task automatic set_pixel_count(input logic [COUNT_W-1:0] pc);
    wait_results_drained();
    repeat (2) @(posedge clk);
    cfg_data  <= pc;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.pixel_count = pc;
  endtask

  // Bin count near the per-bin share of the image, with zeros and extremes mixed in.
  function automatic logic [COUNT_W-1:0] pick_bin_count(input int unsigned share);
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return COUNT_W'(BIN_COUNT_MAX);
    if (pick == 2) return COUNT_W'($urandom_range(0, BIN_COUNT_MAX));
    top = share * 2 + 1;
    if (top > BIN_COUNT_MAX) top = BIN_COUNT_MAX;
    return COUNT_W'($urandom_range(0, top));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_pixel_count();
    case ($urandom_range(0, 7))
      0: return COUNT_W'(1);
      1: return COUNT_W'(BIN_COUNT_MAX);
      2: return '0;
      3: return COUNT_W'($urandom_range(2, 300));
      4: return COUNT_W'(1) << $urandom_range(1, 24);
      default: return COUNT_W'($urandom_range(1, BIN_COUNT_MAX));
    endcase
  endfunction

  // Histogram passes under one pixel count: mostly well-formed bin sequences starting
  // with first_bin, some reads mixed in, occasional restarts and missing starts.
  task automatic run_phase(input logic [COUNT_W-1:0] pc, input int budget);
    int len;
    int b;
    int unsigned share;
    logic first;
    while (budget > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 256) : $urandom_range(2, 40);
      share = int'(pc) / len;
      for (b = 0; b < len && budget > 0; b++) begin
        if (taken >= QUIET_FROM) quiet = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          send_read(sb.pick_written_bin());
          budget--;
          taken++;
        end
        first = (b == 0);
        if ($urandom_range(0, 29) == 0) first = ~first;
        send_request(MODE_ACCUM, first, pick_bin_count(share), READ_W'($urandom_range(0, 255)));
        budget--;
        taken++;
      end
      if ($urandom_range(0, 14) == 0) wait_results_drained();
    end
  endtask

  // Empty image: accumulate requests are dropped, reads still answer with the flag set.
  task automatic run_empty_phase();
    repeat (15) begin
      if ($urandom_range(0, 1) == 0)
        send_read(sb.pick_written_bin());
      else
        send_request(MODE_ACCUM, 1'($urandom_range(0, 1)), pick_bin_count(BIN_COUNT_MAX / 64),
                     READ_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] pc;
    int budget;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pixel_count still at its reset value of zero: every accumulate is an error
    send_request(MODE_ACCUM, 1'b1, COUNT_W'(BIN_COUNT_MAX), 8'd0);
    send_request(MODE_ACCUM, 1'b0, '0, 8'd255);

    // one-pixel image: any nonzero sum saturates the level; drive the sums into saturation
    set_pixel_count(COUNT_W'(1));
    send_request(MODE_ACCUM, 1'b1, '0, 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(1), 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(BIN_COUNT_MAX), 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(BIN_COUNT_MAX), 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(BIN_COUNT_MAX), 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(BIN_COUNT_MAX), 8'd0);
    send_read(0);
    send_read(255);

    // largest image: mid and top levels, then reads of a bin cleared by the new pass
    set_pixel_count(COUNT_W'(BIN_COUNT_MAX));
    send_request(MODE_ACCUM, 1'b1, COUNT_W'(BIN_COUNT_MAX / 2), 8'd0);
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(BIN_COUNT_MAX / 2), 8'd0);
    send_read(127);
    send_read(255);
    send_read(0);
    send_request(MODE_ACCUM, 1'b1, COUNT_W'(65793), 8'd0);   // just below level one
    send_request(MODE_ACCUM, 1'b0, COUNT_W'(1), 8'd0);       // crosses to level one

    // back to an empty image: accumulate with first_bin must not clear anything
    set_pixel_count('0);
    send_read(127);
    send_request(MODE_ACCUM, 1'b1, COUNT_W'(5), 8'd0);
    send_read(1);

    // random phases, each under a fresh pixel count
    while (taken < RANDOM_ITEMS) begin
      pc = pick_pixel_count();
      set_pixel_count(pc);
      if (pc == 0) begin
        run_empty_phase();
      end else begin
        budget = $urandom_range(60, 220);
        if (budget > RANDOM_ITEMS - taken) budget = RANDOM_ITEMS - taken;
        run_phase(pc, budget);
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_bins.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/heq_pkg.sv
rtl/histogram_equalizer.sv
rtl/heq_checker.sv
dv/histogram_equalizer_tb.sv
